@@ hw/rtl/mwsm_pkg.sv @@
// Shared types and constants of the mecanum wheel speed mixer.
package mwsm_pkg;

    localparam int VEL_W       = 16;
    localparam int LIM_W       = 15;
    localparam int ROT_RATIO_W = 24;
    localparam int RPM_RATIO_W = 16;
    localparam int NUM_WHEELS  = 4;
    localparam int Q16_W       = 16;
    localparam int LIN_W       = VEL_W + 2;
    localparam int ROT_W       = VEL_W + ROT_RATIO_W;
    localparam int SUM_W       = ROT_W + 1;
    localparam int PROD_W      = SUM_W + RPM_RATIO_W;
    localparam int FRAC_W      = 32;
    localparam int WHEEL_W     = PROD_W - FRAC_W;
    localparam int MAG_W       = WHEEL_W - 1;
    localparam int NUM_W       = MAG_W + LIM_W;
    localparam int QUO_W       = LIM_W;
    localparam int OUT_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [LIM_W-1:0]       LIMIT_VX_RST  = 15'd330;
    localparam logic [LIM_W-1:0]       LIMIT_VY_RST  = 15'd330;
    localparam logic [LIM_W-1:0]       LIMIT_VW_RST  = 15'd50;
    localparam logic [ROT_RATIO_W-1:0] ROT_RATIO_RST = 24'd600461;
    localparam logic [RPM_RATIO_W-1:0] RPM_RATIO_RST = 16'd12516;
    localparam logic [LIM_W-1:0]       LIMIT_RPM_RST = 15'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_VX  = 3'd0,
        REG_LIMIT_VY  = 3'd1,
        REG_LIMIT_VW  = 3'd2,
        REG_ROT_RATIO = 3'd3,
        REG_RPM_RATIO = 3'd4,
        REG_LIMIT_RPM = 3'd5
    } cfg_reg_t;

    typedef logic signed [WHEEL_W-1:0] wheel_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [NUM_W-1:0]          num_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_turn;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] rpm_front_left;
        logic signed [OUT_W-1:0] rpm_back_left;
        logic signed [OUT_W-1:0] rpm_front_right;
        logic signed [OUT_W-1:0] rpm_back_right;
        logic                    was_scaled;
    } out_t;

    typedef struct packed {
        logic [LIM_W-1:0]       limit_vx;
        logic [LIM_W-1:0]       limit_vy;
        logic [LIM_W-1:0]       limit_vw;
        logic [ROT_RATIO_W-1:0] rotate_ratio;
        logic [RPM_RATIO_W-1:0] rpm_ratio;
        logic [LIM_W-1:0]       limit_rpm;
    } cfg_t;

    // Raw wheel speeds with the scaling operands, handed to the divider.
    typedef struct packed {
        wheel_t [NUM_WHEELS-1:0] w;
        num_t   [NUM_WHEELS-1:0] num;
        mag_t                    mx;
        logic                    scaled;
    } peak_t;

endpackage

@@ hw/rtl/mwsm_kin.sv @@
// Axis clamping and inverse kinematics pipeline giving the raw wheel speeds.
module mwsm_kin
    import mwsm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  in_t                     in_data,
    input  cfg_t                    cfg,
    output logic                    out_valid,
    output wheel_t [NUM_WHEELS-1:0] out_w
);

    localparam logic [PROD_W-1:0] TRUNC_BIAS = (PROD_W'(1) << FRAC_W) - PROD_W'(1);

    function automatic logic signed [VEL_W-1:0] clamp_mag(
        input logic signed [VEL_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [VEL_W:0] v_ext;
        logic signed [VEL_W:0] l_pos;
        logic signed [VEL_W:0] l_neg;
        logic signed [VEL_W-1:0] r;
        v_ext = {v[VEL_W-1], v};
        l_pos = $signed({{(VEL_W + 1 - LIM_W){1'b0}}, lim});
        l_neg = -l_pos;
        if (v_ext > l_pos) begin
            r = l_pos[VEL_W-1:0];
        end else if (v_ext < l_neg) begin
            r = l_neg[VEL_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [4:0] vld_reg;

    logic signed [VEL_W-1:0]   x1_reg, y1_reg, t1_reg;
    logic signed [VEL_W-1:0]   x1_next, y1_next, t1_next;
    logic signed [ROT_W-1:0]   rot2_reg, rot2_next;
    logic signed [LIN_W-1:0]   lin2_reg [NUM_WHEELS];
    logic signed [LIN_W-1:0]   lin2_next [NUM_WHEELS];
    logic signed [SUM_W-1:0]   sum3_reg [NUM_WHEELS];
    logic signed [SUM_W-1:0]   sum3_next [NUM_WHEELS];
    logic signed [PROD_W-1:0]  prod4_reg [NUM_WHEELS];
    logic signed [PROD_W-1:0]  prod4_next [NUM_WHEELS];
    logic signed [WHEEL_W-1:0] w5_reg [NUM_WHEELS];
    logic signed [WHEEL_W-1:0] w5_next [NUM_WHEELS];
    logic [PROD_W-1:0]         adj [NUM_WHEELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_comb begin
        x1_next = clamp_mag(in_data.vel_x, cfg.limit_vx);
        y1_next = clamp_mag(in_data.vel_y, cfg.limit_vy);
        t1_next = clamp_mag(in_data.vel_turn, cfg.limit_vw);

        rot2_next    = t1_reg * $signed({1'b0, cfg.rotate_ratio});
        lin2_next[0] = x1_reg - y1_reg;
        lin2_next[1] = x1_reg + y1_reg;
        lin2_next[2] = -x1_reg - y1_reg;
        lin2_next[3] = -x1_reg + y1_reg;

        for (int i = 0; i < NUM_WHEELS; i++) begin
            sum3_next[i]  = $signed({lin2_reg[i], {Q16_W{1'b0}}}) - rot2_reg;
            prod4_next[i] = sum3_reg[i] * $signed({1'b0, cfg.rpm_ratio});
            // Adding the bias before the arithmetic shift rounds toward zero.
            adj[i] = prod4_reg[i] + (prod4_reg[i][PROD_W-1] ? TRUNC_BIAS : '0);
            w5_next[i] = $signed(adj[i][PROD_W-1:FRAC_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg   <= x1_next;
            y1_reg   <= y1_next;
            t1_reg   <= t1_next;
            rot2_reg <= rot2_next;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                lin2_reg[i]  <= lin2_next[i];
                sum3_reg[i]  <= sum3_next[i];
                prod4_reg[i] <= prod4_next[i];
                w5_reg[i]    <= w5_next[i];
            end
        end
    end

    assign out_valid = vld_reg[4];

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            out_w[i] = w5_reg[i];
        end
    end

endmodule

@@ hw/rtl/mwsm_peak.sv @@
// Wheel magnitudes, largest magnitude and scaling numerators.
module mwsm_peak
    import mwsm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  wheel_t [NUM_WHEELS-1:0] in_w,
    input  logic [LIM_W-1:0]        limit_rpm,
    output logic                    out_valid,
    output peak_t                   out_data
);

    logic [1:0] vld_reg;

    logic signed [WHEEL_W-1:0] wi [NUM_WHEELS];
    logic signed [WHEEL_W-1:0] wn [NUM_WHEELS];
    mag_t                      mag [NUM_WHEELS];
    num_t                      num6_next [NUM_WHEELS];
    mag_t                      pmax6_next [2];
    mag_t                      mx7_next;

    wheel_t w6_reg [NUM_WHEELS];
    num_t   num6_reg [NUM_WHEELS];
    mag_t   pmax6_reg [2];
    peak_t  pk7_reg, pk7_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            wi[i]  = $signed(in_w[i]);
            wn[i]  = -wi[i];
            mag[i] = wi[i][WHEEL_W-1] ? wn[i][MAG_W-1:0] : wi[i][MAG_W-1:0];
            num6_next[i] = NUM_W'(mag[i]) * NUM_W'(limit_rpm);
        end
        pmax6_next[0] = (mag[0] > mag[1]) ? mag[0] : mag[1];
        pmax6_next[1] = (mag[2] > mag[3]) ? mag[2] : mag[3];

        mx7_next = (pmax6_reg[0] > pmax6_reg[1]) ? pmax6_reg[0] : pmax6_reg[1];
        for (int i = 0; i < NUM_WHEELS; i++) begin
            pk7_next.w[i]   = w6_reg[i];
            pk7_next.num[i] = num6_reg[i];
        end
        pk7_next.mx     = mx7_next;
        pk7_next.scaled = mx7_next > MAG_W'(limit_rpm);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                w6_reg[i]   <= wi[i];
                num6_reg[i] <= num6_next[i];
            end
            pmax6_reg[0] <= pmax6_next[0];
            pmax6_reg[1] <= pmax6_next[1];
            pk7_reg      <= pk7_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_data  = pk7_reg;

endmodule

@@ hw/rtl/mwsm_div.sv @@
// Pipelined restoring divider that scales the wheels down to the rpm limit, or passes them through saturated.
module mwsm_div
    import mwsm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  peak_t in_data,
    output logic  out_valid,
    output out_t  out_data
);

    typedef struct packed {
        mag_t             rem;
        logic [QUO_W-1:0] nq;
    } div_step_t;

    // One quotient bit: the next numerator bit leaves the top of nq and the
    // quotient bit enters at the bottom.
    function automatic div_step_t div_step(
        input mag_t             rem,
        input logic [QUO_W-1:0] nq,
        input mag_t             d
    );
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        div_step_t      r;
        trial = {rem, nq[QUO_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            r.rem = diff[MAG_W-1:0];
            r.nq  = {nq[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = trial[MAG_W-1:0];
            r.nq  = {nq[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [WHEEL_W-1:0] w);
        logic signed [WHEEL_W-1:0] hi;
        logic signed [WHEEL_W-1:0] lo;
        logic signed [OUT_W-1:0]   r;
        hi = WHEEL_W'(32767);
        lo = -WHEEL_W'(32768);
        if (w > hi) begin
            r = hi[OUT_W-1:0];
        end else if (w < lo) begin
            r = lo[OUT_W-1:0];
        end else begin
            r = w[OUT_W-1:0];
        end
        return r;
    endfunction

    logic [QUO_W+1:0] vld_reg;

    mag_t                    rem_reg [QUO_W+1][NUM_WHEELS];
    logic [QUO_W-1:0]        nq_reg [QUO_W+1][NUM_WHEELS];
    logic signed [OUT_W-1:0] pass_reg [QUO_W+1][NUM_WHEELS];
    logic                    neg_reg [QUO_W+1][NUM_WHEELS];
    mag_t                    mx_reg [QUO_W+1];
    logic                    scaled_reg [QUO_W+1];

    div_step_t               st_next [QUO_W][NUM_WHEELS];
    logic signed [OUT_W-1:0] res [NUM_WHEELS];
    logic [OUT_W-1:0]        q_ext [NUM_WHEELS];
    out_t                    out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QUO_W:0], in_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                st_next[k][i] = div_step(rem_reg[k][i], nq_reg[k][i], mx_reg[k]);
            end
        end

        for (int i = 0; i < NUM_WHEELS; i++) begin
            q_ext[i] = {1'b0, nq_reg[QUO_W][i]};
            if (scaled_reg[QUO_W]) begin
                res[i] = neg_reg[QUO_W][i] ? $signed(-q_ext[i]) : $signed(q_ext[i]);
            end else begin
                res[i] = pass_reg[QUO_W][i];
            end
        end
        out_next.rpm_front_left  = res[0];
        out_next.rpm_back_left   = res[1];
        out_next.rpm_front_right = res[2];
        out_next.rpm_back_right  = res[3];
        out_next.was_scaled      = scaled_reg[QUO_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Entry stage: the quotient is known to fit in QUO_W bits, so the
            // upper numerator bits already form a remainder below the divisor.
            mx_reg[0]     <= in_data.mx;
            scaled_reg[0] <= in_data.scaled;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                rem_reg[0][i]  <= in_data.num[i][NUM_W-1:QUO_W];
                nq_reg[0][i]   <= in_data.num[i][QUO_W-1:0];
                pass_reg[0][i] <= sat16($signed(in_data.w[i]));
                neg_reg[0][i]  <= in_data.w[i][WHEEL_W-1];
            end
            for (int k = 0; k < QUO_W; k++) begin
                mx_reg[k+1]     <= mx_reg[k];
                scaled_reg[k+1] <= scaled_reg[k];
                for (int i = 0; i < NUM_WHEELS; i++) begin
                    rem_reg[k+1][i]  <= st_next[k][i].rem;
                    nq_reg[k+1][i]   <= st_next[k][i].nq;
                    pass_reg[k+1][i] <= pass_reg[k][i];
                    neg_reg[k+1][i]  <= neg_reg[k][i];
                end
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[QUO_W+1];
    assign out_data  = out_reg;

endmodule

@@ hw/rtl/mecanum_wheel_speed_mixer.sv @@
// Top level of the mecanum wheel speed mixer with its register file and output buffer.
//
// Turns a chassis velocity command (vel_x and vel_y in mm/s, vel_turn in deg/s) into the
// four mecanum wheel speeds in rpm, clamping each axis to its limit and scaling all wheels
// down together when the fastest one exceeds limit_rpm (was_scaled then reads 1).
// A command may be transferred in every clock cycle while s_ready is high, and its result
// reaches m_valid through five stages of clamping, multiplication and truncation, two
// stages of magnitude and peak search, a seventeen stage divider whose middle stages each
// produce one quotient bit for all four wheels in parallel, then the output register.
// A one-entry skid buffer sits behind the output register, so the pipeline keeps running
// while a result waits and s_ready drops only once that buffer is occupied. Registers are
// written through cfg_wr_en, cfg_index and cfg_wr_data and should only change while no
// command is in flight.
module mecanum_wheel_speed_mixer
    import mwsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t cfg_reg, cfg_next;

    logic                    en;
    logic                    kin_valid;
    wheel_t [NUM_WHEELS-1:0] kin_w;
    logic                    peak_valid;
    peak_t                   peak_data;
    logic                    pipe_valid;
    out_t                    pipe_data;
    logic                    push;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;
    logic skid_valid_reg, skid_valid_next;
    out_t skid_data_reg, skid_data_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LIMIT_VX:  cfg_next.limit_vx     = cfg_wr_data[LIM_W-1:0];
                REG_LIMIT_VY:  cfg_next.limit_vy     = cfg_wr_data[LIM_W-1:0];
                REG_LIMIT_VW:  cfg_next.limit_vw     = cfg_wr_data[LIM_W-1:0];
                REG_ROT_RATIO: cfg_next.rotate_ratio = cfg_wr_data[ROT_RATIO_W-1:0];
                REG_RPM_RATIO: cfg_next.rpm_ratio    = cfg_wr_data[RPM_RATIO_W-1:0];
                REG_LIMIT_RPM: cfg_next.limit_rpm    = cfg_wr_data[LIM_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.limit_vx     <= LIMIT_VX_RST;
            cfg_reg.limit_vy     <= LIMIT_VY_RST;
            cfg_reg.limit_vw     <= LIMIT_VW_RST;
            cfg_reg.rotate_ratio <= ROT_RATIO_RST;
            cfg_reg.rpm_ratio    <= RPM_RATIO_RST;
            cfg_reg.limit_rpm    <= LIMIT_RPM_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The whole pipeline advances together unless the skid buffer is holding a result.
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    mwsm_kin u_kin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .out_valid (kin_valid),
        .out_w     (kin_w)
    );

    mwsm_peak u_peak (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (kin_valid),
        .in_w      (kin_w),
        .limit_rpm (cfg_reg.limit_rpm),
        .out_valid (peak_valid),
        .out_data  (peak_data)
    );

    mwsm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (peak_valid),
        .in_data   (peak_data),
        .out_valid (pipe_valid),
        .out_data  (pipe_data)
    );

    always_comb begin
        push            = en && pipe_valid;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = push;
                if (push) begin
                    m_data_next = pipe_data;
                end
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = pipe_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ test/mwsm_speed_checker.sv @@
// Checker for the wheel speed mixer: mirrors the registers, predicts every result and compares.
module mwsm_speed_checker
    import mwsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    fault_count,
    output int                    speeds_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t mixer_regs;
    out_t wheel_speeds_due [$];

    function automatic longint clamp_axis(longint v, logic [LIM_W-1:0] lim);
        longint l;
        l = longint'(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_rpm(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[OUT_W-1:0];
    endfunction

    // Wheel order throughout: front left, back left, front right, back right.
    function automatic out_t mix_wheel_speeds(in_t cmd);
        longint x, y, t, rot, k, lim, peak, mag;
        longint lin [NUM_WHEELS];
        longint w [NUM_WHEELS];
        out_t res;
        x = clamp_axis(longint'(cmd.vel_x), mixer_regs.limit_vx);
        y = clamp_axis(longint'(cmd.vel_y), mixer_regs.limit_vy);
        t = clamp_axis(longint'(cmd.vel_turn), mixer_regs.limit_vw);
        rot = t * longint'(mixer_regs.rotate_ratio);
        k = longint'(mixer_regs.rpm_ratio);
        lim = longint'(mixer_regs.limit_rpm);
        lin[0] = x - y;
        lin[1] = x + y;
        lin[2] = -x - y;
        lin[3] = -x + y;
        peak = 0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            // Both divisions truncate toward zero, as longint division does.
            w[i] = ((lin[i] * 65536 - rot) * k) / (longint'(1) << 32);
            mag = (w[i] < 0) ? -w[i] : w[i];
            if (mag > peak) peak = mag;
        end
        res.was_scaled = (peak > lim);
        if (res.was_scaled) begin
            for (int i = 0; i < NUM_WHEELS; i++) w[i] = (w[i] * lim) / peak;
        end
        res.rpm_front_left  = sat_rpm(w[0]);
        res.rpm_back_left   = sat_rpm(w[1]);
        res.rpm_front_right = sat_rpm(w[2]);
        res.rpm_back_right  = sat_rpm(w[3]);
        return res;
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fault_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            mixer_regs.limit_vx     = LIMIT_VX_RST;
            mixer_regs.limit_vy     = LIMIT_VY_RST;
            mixer_regs.limit_vw     = LIMIT_VW_RST;
            mixer_regs.rotate_ratio = ROT_RATIO_RST;
            mixer_regs.rpm_ratio    = RPM_RATIO_RST;
            mixer_regs.limit_rpm    = LIMIT_RPM_RST;
            wheel_speeds_due.delete();
            fault_count = 0;
        end else begin
            // The command is predicted with the registers as they stood before this edge.
            if (s_valid && s_ready) wheel_speeds_due.push_back(mix_wheel_speeds(s_data));
            if (m_valid && m_ready) begin
                if (wheel_speeds_due.size() == 0) begin
                    $error("result transfer with no command waiting for it");
                    fault_count++;
                end else begin
                    want = wheel_speeds_due.pop_front();
                    check_field("rpm_front_left", longint'(want.rpm_front_left),
                                longint'(m_data.rpm_front_left));
                    check_field("rpm_back_left", longint'(want.rpm_back_left),
                                longint'(m_data.rpm_back_left));
                    check_field("rpm_front_right", longint'(want.rpm_front_right),
                                longint'(m_data.rpm_front_right));
                    check_field("rpm_back_right", longint'(want.rpm_back_right),
                                longint'(m_data.rpm_back_right));
                    check_field("was_scaled", longint'(want.was_scaled),
                                longint'(m_data.was_scaled));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LIMIT_VX:  mixer_regs.limit_vx     = cfg_wr_data[LIM_W-1:0];
                    REG_LIMIT_VY:  mixer_regs.limit_vy     = cfg_wr_data[LIM_W-1:0];
                    REG_LIMIT_VW:  mixer_regs.limit_vw     = cfg_wr_data[LIM_W-1:0];
                    REG_ROT_RATIO: mixer_regs.rotate_ratio = cfg_wr_data[ROT_RATIO_W-1:0];
                    REG_RPM_RATIO: mixer_regs.rpm_ratio    = cfg_wr_data[RPM_RATIO_W-1:0];
                    REG_LIMIT_RPM: mixer_regs.limit_rpm    = cfg_wr_data[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
        speeds_outstanding = wheel_speeds_due.size();
    end

endmodule

@@ test/mecanum_wheel_speed_mixer_tb.sv @@
// Testbench top for the wheel speed mixer: clock, reset, command and register stimulus, verdict.
module mecanum_wheel_speed_mixer_tb
    import mwsm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 135;
    localparam int TAKE_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 40;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam in_t PROBES [22] = '{
        {16'h0000, 16'h0000, 16'h0000}, {16'h7FFF, 16'h0000, 16'h0000},
        {16'h8000, 16'h0000, 16'h0000}, {16'h0000, 16'h7FFF, 16'h0000},
        {16'h0000, 16'h8000, 16'h0000}, {16'h0000, 16'h0000, 16'h7FFF},
        {16'h0000, 16'h0000, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
        {16'h8000, 16'h8000, 16'h8000}, {16'h7FFF, 16'h8000, 16'h0000},
        {16'h8000, 16'h7FFF, 16'h0000}, {16'h014A, 16'hFEB6, 16'h0032},
        {16'h014B, 16'h014B, 16'h0033}, {16'hFEB5, 16'hFEB5, 16'hFFCD},
        {16'h0064, 16'h0000, 16'h0000}, {16'h0000, 16'h0064, 16'h0000},
        {16'h0000, 16'h0000, 16'h000A}, {16'h0001, 16'h0001, 16'h0001},
        {16'hFFFF, 16'hFFFF, 16'hFFFF}, {16'h5555, 16'hAAAA, 16'h5555},
        {16'hAAAA, 16'h5555, 16'hAAAA}, {16'h014A, 16'h014A, 16'hFFCE}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int fault_count;
    int speeds_outstanding;
    int send_idle_pct = 25;
    int take_idle_pct = 50;
    int hold_left = 0;
    int hold_reqs = 0;
    int holds_seen = 0;

    mecanum_wheel_speed_mixer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    mwsm_speed_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data             (s_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data             (m_data),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .fault_count        (fault_count),
        .speeds_outstanding (speeds_outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: random back-pressure, or a long hold-off when one is requested.
    always begin
        @(negedge aclk);
        if (hold_reqs != holds_seen) begin
            holds_seen = hold_reqs;
            hold_left = TAKE_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Ends the run when no transfer has happened for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Called and left at a falling edge; the command stays offered until its transfer.
    task automatic send_command(in_t cmd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= cmd;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (speeds_outstanding != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
    endtask

    // Upper data bits beyond a narrower register's width carry noise that must be dropped.
    task automatic load_settings(cfg_t c);
        logic [8:0] noise_hi;
        logic [7:0] noise_lo;
        noise_hi = 9'($urandom);
        noise_lo = 8'($urandom);
        write_reg(REG_LIMIT_VX, {noise_hi, c.limit_vx});
        write_reg(REG_LIMIT_VY, {noise_lo, 1'b1, c.limit_vy});
        write_reg(REG_LIMIT_VW, {noise_hi, c.limit_vw});
        write_reg(REG_ROT_RATIO, c.rotate_ratio);
        write_reg(REG_RPM_RATIO, {noise_lo, c.rpm_ratio});
        write_reg(REG_LIMIT_RPM, {noise_hi, c.limit_rpm});
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Values around the clamp limit, full-range noise, small values near zero and the extremes.
    function automatic logic [VEL_W-1:0] pick_vel(logic [LIM_W-1:0] lim);
        int l;
        int v;
        l = int'(lim);
        case ($urandom_range(5))
            0, 1: v = $urandom;
            2: v = int'($urandom_range(2 * l)) - l;
            3: v = ($urandom_range(1) ? 1 : -1) * (l + int'($urandom_range(1)));
            4: v = int'($urandom_range(20)) - 10;
            default: v = $urandom_range(1) ? 32767 : -32768;
        endcase
        return v[VEL_W-1:0];
    endfunction

    initial begin
        cfg_t next_cfg;
        in_t next_cmd;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (PROBES[i]) send_command(PROBES[i]);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: next_cfg = '{limit_vx: 15'd500, limit_vy: 15'd550, limit_vw: 15'd100,
                                rotate_ratio: ROT_RATIO_RST, rpm_ratio: RPM_RATIO_RST,
                                limit_rpm: 15'd200};
                1: next_cfg = '{limit_vx: 15'h7FFF, limit_vy: 15'h7FFF, limit_vw: 15'h7FFF,
                                rotate_ratio: 24'hFFFFFF, rpm_ratio: 16'hFFFF,
                                limit_rpm: 15'h7FFF};
                2: next_cfg = '{limit_vx: '0, limit_vy: '0, limit_vw: '0,
                                rotate_ratio: '0, rpm_ratio: '0, limit_rpm: 15'd1};
                // A zero rpm limit forces every moving command to all-zero wheels.
                3: next_cfg = '{limit_vx: LIMIT_VX_RST, limit_vy: LIMIT_VY_RST,
                                limit_vw: LIMIT_VW_RST, rotate_ratio: ROT_RATIO_RST,
                                rpm_ratio: RPM_RATIO_RST, limit_rpm: '0};
                4: next_cfg = '{limit_vx: LIM_W'($urandom_range(1, 2000)),
                                limit_vy: LIM_W'($urandom_range(1, 2000)),
                                limit_vw: LIM_W'($urandom_range(1, 400)),
                                rotate_ratio: ROT_RATIO_W'($urandom_range(2000000)),
                                rpm_ratio: RPM_RATIO_W'($urandom),
                                limit_rpm: LIM_W'($urandom_range(1, 400))};
                5: next_cfg = '{limit_vx: 15'h7FFF, limit_vy: 15'h7FFF, limit_vw: 15'h7FFF,
                                rotate_ratio: ROT_RATIO_W'($urandom), rpm_ratio: 16'hFFFF,
                                limit_rpm: 15'd1};
                6: next_cfg = '{limit_vx: LIM_W'($urandom), limit_vy: LIM_W'($urandom),
                                limit_vw: LIM_W'($urandom),
                                rotate_ratio: ROT_RATIO_W'($urandom),
                                rpm_ratio: RPM_RATIO_W'($urandom),
                                limit_rpm: LIM_W'($urandom)};
                default: next_cfg = '{limit_vx: LIMIT_VX_RST, limit_vy: LIMIT_VY_RST,
                                      limit_vw: LIMIT_VW_RST, rotate_ratio: ROT_RATIO_RST,
                                      rpm_ratio: RPM_RATIO_RST, limit_rpm: 15'h7FFF};
            endcase
            load_settings(next_cfg);
            if (phase == 3) begin
                send_idle_pct = 50;
                take_idle_pct = 25;
            end else if (phase == 6) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 4 && n == ITEMS_PER_PHASE / 2) drain_results();
                // The sender keeps going while results are held back, so the input stalls.
                if (phase == 7 && n == 20) hold_reqs++;
                next_cmd.vel_x = pick_vel(next_cfg.limit_vx);
                next_cmd.vel_y = pick_vel(next_cfg.limit_vy);
                next_cmd.vel_turn = pick_vel(next_cfg.limit_vw);
                send_command(next_cmd);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fault_count == 0 && speeds_outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
